// ----- hdl/sjfa_pkg.sv -----
// sjfa_pkg: shared types and constants of the shift-jis font rom address unit
// holds the result record and the rom layout constants
// no dependencies
package sjfa_pkg;

    // field widths
    localparam int CODE_W  = 16;
    localparam int SIZE_W  = 5;
    localparam int ADDR_W  = 20;
    localparam int WIDTH_W = 5;
    localparam int ROWB_W  = 2;

    // internal address width, wide enough to hold any out-of-range address
    localparam int WADDR_W = 24;

    // reset value of the font size register
    localparam logic [SIZE_W-1:0] FONT_SIZE_RESET = 5'd24;

    // supported font sizes
    localparam logic [SIZE_W-1:0] SIZE_8  = 5'd8;
    localparam logic [SIZE_W-1:0] SIZE_16 = 5'd16;
    localparam logic [SIZE_W-1:0] SIZE_24 = 5'd24;

    // rom layout: half-width tables
    localparam logic [WADDR_W-1:0] HALF8_BASE  = 24'h03A000;
    localparam logic [WADDR_W-1:0] HALF16_BASE = 24'h03A800;
    localparam logic [WADDR_W-1:0] HALF24_BASE = 24'h03D000;

    // rom layout: full-width tables
    localparam logic [WADDR_W-1:0] NONKANJI16_BASE = 24'h000000;
    localparam logic [WADDR_W-1:0] NONKANJI24_BASE = 24'h040000;
    localparam logic [WADDR_W-1:0] KANJI16_BASE    = 24'h005E00;
    localparam logic [WADDR_W-1:0] KANJI24_BASE    = 24'h04D380;
    localparam logic [WADDR_W-1:0] ROM_LIMIT       = 24'h0C0000;

    // jis cell arithmetic
    localparam logic [15:0] JIS_NONKANJI_ORG = 16'h2121;
    localparam logic [15:0] JIS_KANJI_ORG    = 16'h3021;
    localparam logic [15:0] JIS_KANJI_ROW    = 16'h3000;
    localparam logic [15:0] CELLS_PER_ROW    = 16'h005E;

    // one result item
    typedef struct packed {
        logic               valid_res;
        logic [ADDR_W-1:0]  font_address;
        logic [WIDTH_W-1:0] glyph_width;
        logic [ROWB_W-1:0]  row_bytes;
    } result_t;

endpackage

// ----- hdl/sjfa_map.sv -----
// sjfa_map: combinational code to glyph address mapping
// range checks, shift-jis to jis conversion, cell index and rom address
// depends on sjfa_pkg
module sjfa_map (
    input  logic [sjfa_pkg::CODE_W-1:0] char_code,
    input  logic [sjfa_pkg::SIZE_W-1:0] font_size,
    output sjfa_pkg::result_t           res
);
    import sjfa_pkg::*;

    logic [7:0]         hi;
    logic [7:0]         lo;
    logic               code_ok;
    logic               half;
    logic [7:0]         hb_sh;
    logic [7:0]         hb;
    logic [7:0]         lb;
    logic [15:0]        jis;
    logic [15:0]        diff;
    logic [15:0]        idx;
    logic [WADDR_W-1:0] idx_w;
    logic [WADDR_W-1:0] hi_w;
    logic [WADDR_W-1:0] addr;
    logic [WIDTH_W-1:0] width;
    logic               ok;
    logic [WIDTH_W:0]   width_rnd;

    assign hi = char_code[15:8];
    assign lo = char_code[7:0];

    // code range check
    always_comb
    begin
        if (lo == 8'h00)
        begin
            code_ok = (hi >= 8'h20) && (hi <= 8'hDF);
        end
        else
        begin
            code_ok = ((hi >= 8'h81 && hi <= 8'h9F) || (hi >= 8'hE0 && hi <= 8'hEF))
                      && (lo >= 8'h40) && (lo <= 8'hFC);
        end
    end

    // half-width lead byte
    assign half = (hi >= 8'h20 && hi <= 8'h80) || (hi >= 8'hA0 && hi <= 8'hDF);

    // shift-jis to jis, each byte wrapping at 8 bits
    assign hb_sh = {hi[6:0], 1'b0};
    always_comb
    begin
        if (lo < 8'h9F)
        begin
            hb = (hb_sh < 8'h3F) ? hb_sh + 8'h1F : hb_sh - 8'h61;
            lb = (lo > 8'h7E) ? lo - 8'h20 : lo - 8'h1F;
        end
        else
        begin
            hb = (hb_sh < 8'h3F) ? hb_sh + 8'h20 : hb_sh - 8'h60;
            lb = lo - 8'h7E;
        end
    end
    assign jis = {hb, lb};

    // linear cell index, 16-bit wrap
    assign diff = (jis >= JIS_KANJI_ROW) ? jis - JIS_KANJI_ORG : jis - JIS_NONKANJI_ORG;
    assign idx  = {8'h00, diff[7:0]} + ({8'h00, diff[15:8]} * CELLS_PER_ROW);

    assign idx_w = {{(WADDR_W-16){1'b0}}, idx};
    assign hi_w  = {{(WADDR_W-8){1'b0}}, hi};

    // glyph address and width selection
    always_comb
    begin
        addr  = '0;
        width = '0;
        ok    = 1'b0;
        if (code_ok)
        begin
            if (half)
            begin
                case (font_size)
                    SIZE_8:
                    begin
                        addr  = HALF8_BASE + {hi_w[WADDR_W-4:0], 3'b000};
                        width = 5'd8;
                        ok    = 1'b1;
                    end
                    SIZE_16:
                    begin
                        addr  = HALF16_BASE + {hi_w[WADDR_W-5:0], 4'b0000};
                        width = 5'd8;
                        ok    = 1'b1;
                    end
                    SIZE_24:
                    begin
                        addr  = HALF24_BASE + {hi_w[WADDR_W-5:0], 4'b0000}
                                + {hi_w[WADDR_W-6:0], 5'b00000};
                        width = 5'd12;
                        ok    = 1'b1;
                    end
                    default:
                    begin
                        ok = 1'b0;
                    end
                endcase
            end
            else if (font_size == SIZE_16 || font_size == SIZE_24)
            begin
                // 32 bytes per 16 dot glyph, 72 per 24 dot glyph
                if (hb >= 8'h21 && hb <= 8'h28)
                begin
                    if (font_size == SIZE_16)
                    begin
                        addr = NONKANJI16_BASE + {idx_w[WADDR_W-6:0], 5'b00000};
                    end
                    else
                    begin
                        addr = NONKANJI24_BASE + {idx_w[WADDR_W-7:0], 6'b000000}
                               + {idx_w[WADDR_W-4:0], 3'b000};
                    end
                    width = font_size;
                    ok    = 1'b1;
                end
                else if (hb >= 8'h30 && hb <= 8'h74)
                begin
                    if (font_size == SIZE_16)
                    begin
                        addr = KANJI16_BASE + {idx_w[WADDR_W-6:0], 5'b00000};
                    end
                    else
                    begin
                        addr = KANJI24_BASE + {idx_w[WADDR_W-7:0], 6'b000000}
                               + {idx_w[WADDR_W-4:0], 3'b000};
                    end
                    width = font_size;
                    ok    = 1'b1;
                end
            end
        end
    end

    // rom limit and clearing of invalid results
    always_comb
    begin
        width_rnd = {1'b0, width} + 6'd7;
        if (ok && (addr <= ROM_LIMIT))
        begin
            res.valid_res    = 1'b1;
            res.font_address = addr[ADDR_W-1:0];
            res.glyph_width  = width;
            res.row_bytes    = width_rnd[ROWB_W+2:3];
        end
        else
        begin
            res.valid_res    = 1'b0;
            res.font_address = '0;
            res.glyph_width  = '0;
            res.row_bytes    = '0;
        end
    end

endmodule

// ----- hdl/sjis_font_rom_address.sv -----
// sjis_font_rom_address: top level of the shift-jis font rom address unit
// input register, mapping logic and result register with stream handshakes
// depends on sjfa_pkg and sjfa_map
//
//  channel      | direction | payload
//  -------------+-----------+----------------------------------------------
//  s_axis       | in        | tdata: char_code
//  m_axis       | out       | tuser: valid_res; tdata: font_address,
//               |           |   glyph_width, row_bytes
//  font_size_wr | in        | font_size, write only
//
// one transfer per clock in both directions while m_axis_tready is high; a
// result is offered on m_axis once it has passed the input register, then
// the result register
// rst_n clears both stage valids and loads font_size with 24
// a stalled output holds both stages; s_axis_tready drops only when both
// stages are full and m_axis_tready is low
module sjis_font_rom_address (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,   // [15:0] char_code
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,   // [19:0] font_address,
                                                          // [24:20] glyph_width,
                                                          // [26:25] row_bytes
    output logic                          m_axis_tuser,   // [0] valid_res
    input  logic                          font_size_wr_en,
    input  logic [sjfa_pkg::SIZE_W-1:0]   font_size_wr_data
);
    import sjfa_pkg::*;

    logic [SIZE_W-1:0] font_size_reg;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [CODE_W-1:0] code_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           res_reg;
    result_t           res_next;
    logic              out_adv;
    logic              in_adv;

    // stage advance
    assign out_adv = !out_valid_reg || m_axis_tready;
    assign in_adv  = !in_valid_reg || out_adv;

    assign s_axis_tready  = in_adv;
    assign in_valid_next  = in_adv ? s_axis_tvalid : in_valid_reg;
    assign out_valid_next = out_adv ? in_valid_reg : out_valid_reg;

    // font size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_size_reg <= FONT_SIZE_RESET;
        end
        else if (font_size_wr_en)
        begin
            font_size_reg <= font_size_wr_data;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_adv && s_axis_tvalid)
        begin
            code_reg <= s_axis_tdata;
        end
    end

    // mapping logic
    sjfa_map u_map (
        .char_code (code_reg),
        .font_size (font_size_reg),
        .res       (res_next)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (out_adv && in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    // output transfer
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = res_reg.valid_res;
    assign m_axis_tdata  = {5'b00000, res_reg.row_bytes, res_reg.glyph_width,
                            res_reg.font_address};

endmodule
